// ===== hdl/sfe_pkg.sv =====
// shared types and constants of the stuffed frame encoder
`default_nettype none

package sfe_pkg;

   // frame delimiter, sent raw as header and footer
   localparam logic [7:0] DELIM_BYTE = 8'h7E;

   // command codes of the input channel
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // register indexes and reset values of the csr port
   localparam logic       CSR_ESCAPE_BYTE     = 1'b0;
   localparam logic       CSR_CHECKSUM_METHOD = 1'b1;
   localparam logic [7:0] ESCAPE_RESET        = 8'd125;
   localparam logic [3:0] METHOD_RESET        = 4'd0;

   // payload counter width, enough for the largest frame length
   localparam int COUNT_WIDTH = 5;

   // content bytes carried by one queued job
   localparam int MAX_JOB_BYTES = 5;
   localparam int JOB_IDX_WIDTH = 3;

   // one job for the back end: content bytes plus framing flags
   typedef struct packed {
      logic                                head;
      logic                                tail;
      logic [JOB_IDX_WIDTH-1:0]            nbytes;
      logic [MAX_JOB_BYTES-1:0][7:0]       bytes;
   } job_type;

   // sequencer states of the back end
   typedef enum logic [1:0] {
      ST_HEAD,
      ST_BODY,
      ST_TAIL
   } back_state_type;

endpackage : sfe_pkg

`default_nettype wire

// ===== hdl/sfe_if.sv =====
// channel interfaces of the stuffed frame encoder
`default_nettype none

interface sfe_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [3:0] seq_num;
   logic [3:0] ack_num;
   logic [3:0] frame_count;
   logic [7:0] src_addr;
   logic [7:0] dst_addr;
   logic [7:0] data_byte;

   modport source (output valid, cmd, seq_num, ack_num, frame_count, src_addr, dst_addr,
                   data_byte, input ready);
   modport sink (input valid, cmd, seq_num, ack_num, frame_count, src_addr, dst_addr,
                 data_byte, output ready);
endinterface : sfe_req_if

interface sfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_end;

   modport source (output valid, out_byte, run_last, frame_end, input ready);
   modport sink (input valid, out_byte, run_last, frame_end, output ready);
endinterface : sfe_rsp_if

`default_nettype wire

// ===== hdl/sfe_front.sv =====
// front end: accepts transactions, tracks the frame and checksums, builds jobs
`default_nettype none

module sfe_front
   import sfe_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 23
) (
   input  wire logic      clock,
   input  wire logic      reset,
   sfe_req_if.sink        req_ch,
   input  wire logic [3:0] checksum_method,
   input  wire logic      queue_full,
   output job_type        push_job,
   output logic           push
);

   logic                   in_frame_ff, in_frame_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [7:0]             sum1_ff, sum1_in;
   logic [7:0]             sum2_ff, sum2_in;

   logic                   accept;
   logic [COUNT_WIDTH-1:0] count_next;
   logic [7:0]             sum1_next, sum2_next;
   logic                   frame_done;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;

   // running fletcher-style sums (modulo 256) and payload position
   assign sum1_next  = sum1_ff + req_ch.data_byte;
   assign sum2_next  = sum2_ff + sum1_next;
   assign count_next = count_ff + COUNT_WIDTH'(1);
   assign frame_done = (count_next >= COUNT_WIDTH'(PAYLOAD_BYTES)) ||
                       (count_next == '0);

   // payload outside a frame is taken and dropped
   assign push = accept && ((req_ch.cmd == CMD_START) || in_frame_ff);

   // job contents
   always_comb begin
      push_job = '0;
      if (req_ch.cmd == CMD_START) begin
         push_job.head     = 1'b1;
         push_job.tail     = 1'b0;
         push_job.nbytes   = JOB_IDX_WIDTH'(MAX_JOB_BYTES);
         push_job.bytes[0] = {req_ch.seq_num, req_ch.ack_num};
         push_job.bytes[1] = {checksum_method, req_ch.frame_count};
         push_job.bytes[2] = req_ch.src_addr;
         push_job.bytes[3] = req_ch.dst_addr;
         push_job.bytes[4] = 8'(PAYLOAD_BYTES);
      end else begin
         push_job.head     = 1'b0;
         push_job.tail     = frame_done;
         push_job.nbytes   = frame_done ? JOB_IDX_WIDTH'(3) : JOB_IDX_WIDTH'(1);
         push_job.bytes[0] = req_ch.data_byte;
         push_job.bytes[1] = sum1_next;
         push_job.bytes[2] = sum2_next;
      end
   end

   // frame state update
   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      sum1_in     = sum1_ff;
      sum2_in     = sum2_ff;
      if (push) begin
         if (req_ch.cmd == CMD_START) begin
            in_frame_in = 1'b1;
            count_in    = '0;
            sum1_in     = '0;
            sum2_in     = '0;
         end else begin
            sum1_in = sum1_next;
            sum2_in = sum2_next;
            if (frame_done) begin
               in_frame_in = 1'b0;
               count_in    = '0;
            end else begin
               count_in = count_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         sum1_ff     <= '0;
         sum2_ff     <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         sum1_ff     <= sum1_in;
         sum2_ff     <= sum2_in;
      end
   end

   // a start transaction always opens a fresh frame
   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.cmd == CMD_START) |=> in_frame_ff && (count_ff == '0))
      else $error("start transaction did not open a frame");

   // the job that carries the sums closes the frame
   a_tail_closes: assert property (@(posedge clock) disable iff (reset)
      push && push_job.tail |=> !in_frame_ff)
      else $error("frame still open after checksum job");

   // counter idles at zero outside a frame
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (count_ff == '0))
      else $error("payload count nonzero outside a frame");

endmodule : sfe_front

`default_nettype wire

// ===== hdl/sfe_queue.sv =====
// job queue between front and back end
`default_nettype none

module sfe_queue
   import sfe_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  job_type      push_job,
   input  wire logic    pop,
   output job_type      head_job,
   output logic         head_valid,
   output logic         full
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   job_type                mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_WIDTH'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(DEPTH))
      else $error("queue fill count out of range");

endmodule : sfe_queue

`default_nettype wire

// ===== hdl/sfe_back.sv =====
// back end: walks each job and emits framed, escaped bytes
`default_nettype none

module sfe_back
   import sfe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  job_type         head_job,
   input  wire logic       head_valid,
   input  wire logic [7:0] escape_byte,
   output logic            pop,
   sfe_rsp_if.source       rsp_ch
);

   back_state_type           st_ff, st_in;
   logic [JOB_IDX_WIDTH-1:0] idx_ff, idx_in;
   logic                     esc_ff, esc_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;
   logic       rsp_end_ff;

   logic       out_free;
   logic       fire;
   logic [7:0] cur_byte;
   logic       needs_esc;
   logic       body_last;
   logic       in_body;

   logic [7:0] emit_byte;
   logic       emit_last;
   logic       emit_end;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign fire      = head_valid && out_free;
   assign cur_byte  = head_job.bytes[idx_ff];
   assign needs_esc = (cur_byte == DELIM_BYTE) && !esc_ff;
   assign body_last = (idx_ff == head_job.nbytes - JOB_IDX_WIDTH'(1));
   assign in_body   = (st_ff == ST_BODY) || ((st_ff == ST_HEAD) && !head_job.head);

   // output byte selection
   always_comb begin
      emit_byte = cur_byte;
      emit_last = 1'b0;
      emit_end  = 1'b0;
      pop       = 1'b0;
      if (st_ff == ST_TAIL) begin
         emit_byte = DELIM_BYTE;
         emit_last = 1'b1;
         emit_end  = 1'b1;
         pop       = fire;
      end else if (!in_body) begin
         emit_byte = DELIM_BYTE;
      end else if (needs_esc) begin
         emit_byte = escape_byte;
      end else if (body_last && !head_job.tail) begin
         emit_last = 1'b1;
         pop       = fire;
      end
   end

   // sequencer next state
   always_comb begin
      st_in  = st_ff;
      idx_in = idx_ff;
      esc_in = esc_ff;
      if (fire) begin
         unique case (st_ff)
            ST_TAIL: begin
               st_in  = ST_HEAD;
               idx_in = '0;
            end
            ST_HEAD, ST_BODY: begin
               if (!in_body) begin
                  st_in  = ST_BODY;
                  idx_in = '0;
               end else if (needs_esc) begin
                  st_in  = ST_BODY;
                  esc_in = 1'b1;
               end else begin
                  esc_in = 1'b0;
                  if (body_last) begin
                     st_in  = head_job.tail ? ST_TAIL : ST_HEAD;
                     idx_in = '0;
                  end else begin
                     st_in  = ST_BODY;
                     idx_in = idx_ff + JOB_IDX_WIDTH'(1);
                  end
               end
            end
            default: begin
               st_in  = ST_HEAD;
               idx_in = '0;
            end
         endcase
      end
   end

   // output register, refilled whenever it is free and a job is waiting
   assign rsp_valid_in = out_free ? fire : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_HEAD;
         idx_ff       <= '0;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         idx_ff       <= idx_in;
         esc_ff       <= esc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= emit_last;
         rsp_end_ff  <= emit_end;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_byte  = rsp_byte_ff;
   assign rsp_ch.run_last  = rsp_last_ff;
   assign rsp_ch.frame_end = rsp_end_ff;

   // footer is always the delimiter and ends its transaction's output
   a_footer_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_end_ff |-> (rsp_byte_ff == DELIM_BYTE) && rsp_last_ff)
      else $error("footer byte malformed");

   // the escape flag is only pending on a delimiter content byte
   a_esc_pending: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> head_valid && (cur_byte == DELIM_BYTE) && (st_ff == ST_BODY))
      else $error("escape pending on a non-delimiter byte");

   // the job index stays within the job
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff < JOB_IDX_WIDTH'(MAX_JOB_BYTES))
      else $error("job byte index out of range");

endmodule : sfe_back

`default_nettype wire

// ===== hdl/stuffed_frame_encoder.sv =====
// top level: csr registers, front end, job queue and back end
// a transaction's output passes through the job queue and then the back-end output register
// the back-end sequencer emits one output byte per cycle while the output is taken and a job
//   is queued; a transaction yields 1 or 2 bytes per payload byte, up to 11 per job
// the front end accepts a new transaction every cycle while the job queue has room
// reset (synchronous, active high) closes any frame, clears sums and the queue,
//   and sets escape byte to 0x7D and checksum method to 0
`default_nettype none

module stuffed_frame_encoder
   import sfe_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 23,
   parameter int QUEUE_DEPTH   = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   sfe_req_if.sink         req_ch,
   sfe_rsp_if.source       rsp_ch,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);

   logic [7:0] escape_ff;
   logic [3:0] method_ff;

   job_type push_job;
   job_type head_job;
   logic    push;
   logic    pop;
   logic    head_valid;
   logic    queue_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= ESCAPE_RESET;
         method_ff <= METHOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ESCAPE_BYTE:     escape_ff <= csr_wdata;
            CSR_CHECKSUM_METHOD: method_ff <= csr_wdata[3:0];
            default:             escape_ff <= escape_ff;
         endcase
      end
   end

   sfe_front #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .checksum_method (method_ff),
      .queue_full      (queue_full),
      .push_job        (push_job),
      .push            (push)
   );

   sfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   sfe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .head_valid  (head_valid),
      .escape_byte (escape_ff),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule : stuffed_frame_encoder

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench of the stuffed frame encoder: directed and random framed traffic against a predictor

module tb_top
   import sfe_pkg::*;
();

   localparam int FRAME_LEN     = 23;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 250;
   localparam int PHASE_ITEMS   = 64;

   // one input transaction and one output byte
   typedef struct packed {
      logic       cmd;
      logic [3:0] seq_num;
      logic [3:0] ack_num;
      logic [3:0] frame_count;
      logic [7:0] src_addr;
      logic [7:0] dst_addr;
      logic [7:0] data_byte;
   } frame_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } frame_byte_type;

   // frame predictor and the bytes it still waits for
   class frame_scoreboard;
      logic [7:0]     escape_code;
      logic [3:0]     method_code;
      bit             open_frame;
      logic [4:0]     pay_count;
      logic [7:0]     sum_a;
      logic [7:0]     sum_b;
      frame_byte_type pending[$];
      int             fail_count;

      function new();
         escape_code = ESCAPE_RESET;
         method_code = METHOD_RESET;
         open_frame  = 1'b0;
         pay_count   = '0;
         sum_a       = '0;
         sum_b       = '0;
         fail_count  = 0;
      endfunction

      function void push_raw(logic [7:0] b, logic endf);
         frame_byte_type e;
         e.out_byte  = b;
         e.run_last  = 1'b0;
         e.frame_end = endf;
         pending.push_back(e);
      endfunction

      // content delimiter gets the escape byte in front
      function void push_content(logic [7:0] b);
         if (b == DELIM_BYTE) push_raw(escape_code, 1'b0);
         push_raw(b, 1'b0);
      endfunction

      // expected bytes of one accepted transaction
      function void note_item(frame_req_type it);
         int first;
         first = pending.size();
         if (it.cmd == CMD_START) begin
            push_raw(DELIM_BYTE, 1'b0);
            push_content({it.seq_num, it.ack_num});
            push_content({method_code, it.frame_count});
            push_content(it.src_addr);
            push_content(it.dst_addr);
            push_content(8'(FRAME_LEN));
            open_frame = 1'b1;
            pay_count  = '0;
            sum_a      = '0;
            sum_b      = '0;
         end else if (open_frame) begin
            push_content(it.data_byte);
            sum_a     = sum_a + it.data_byte;
            sum_b     = sum_b + sum_a;
            pay_count = pay_count + 5'd1;
            if (pay_count >= FRAME_LEN || pay_count == 0) begin
               push_content(sum_a);
               push_content(sum_b);
               push_raw(DELIM_BYTE, 1'b1);
               open_frame = 1'b0;
               pay_count  = '0;
            end
         end
         if (pending.size() > first) pending[pending.size() - 1].run_last = 1'b1;
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         fail_count++;
      endtask

      // compare one output byte with the oldest expectation
      task check_result(frame_byte_type got);
         frame_byte_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected output byte %02h", got.out_byte));
         end else begin
            want = pending.pop_front();
            if (got.out_byte !== want.out_byte)
               report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
            if (got.run_last !== want.run_last)
               report($sformatf("run_last %b, want %b on byte %02h", got.run_last,
                                want.run_last, want.out_byte));
            if (got.frame_end !== want.frame_end)
               report($sformatf("frame_end %b, want %b on byte %02h", got.frame_end,
                                want.frame_end, want.out_byte));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;

   sfe_req_if req_bus ();
   sfe_rsp_if rsp_bus ();

   frame_scoreboard board;
   bit send_idle = 1'b1;
   bit rsp_idle  = 1'b1;
   int rsp_hold  = 0;
   int payload_items = 0;

   stuffed_frame_encoder #(
      .PAYLOAD_BYTES(FRAME_LEN)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // byte values that hit the escaping logic often
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return DELIM_BYTE;
         1: return board.escape_code;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic frame_req_type make_start(logic [3:0] seq, logic [3:0] ack,
                                                logic [3:0] fc, logic [7:0] src,
                                                logic [7:0] dst);
      frame_req_type it;
      it.cmd         = CMD_START;
      it.seq_num     = seq;
      it.ack_num     = ack;
      it.frame_count = fc;
      it.src_addr    = src;
      it.dst_addr    = dst;
      it.data_byte   = 8'($urandom);
      return it;
   endfunction

   function automatic frame_req_type make_data(logic [7:0] b);
      frame_req_type it;
      it.cmd         = CMD_DATA;
      it.seq_num     = 4'($urandom);
      it.ack_num     = 4'($urandom);
      it.frame_count = 4'($urandom);
      it.src_addr    = 8'($urandom);
      it.dst_addr    = 8'($urandom);
      it.data_byte   = b;
      return it;
   endfunction

   // offer one transaction, after a random gap while send_idle is set, note it once accepted
   task automatic send_item(input frame_req_type it);
      int gap;
      gap = send_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= it.cmd;
      req_bus.seq_num     <= it.seq_num;
      req_bus.ack_num     <= it.ack_num;
      req_bus.frame_count <= it.frame_count;
      req_bus.src_addr    <= it.src_addr;
      req_bus.dst_addr    <= it.dst_addr;
      req_bus.data_byte   <= it.data_byte;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_item(it);
   endtask

   // stop offering and wait until every expected byte is out
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [7:0] esc, input logic [3:0] meth);
      csr_we    <= 1'b1;
      csr_index <= CSR_ESCAPE_BYTE;
      csr_wdata <= esc;
      @(posedge clock);
      csr_index <= CSR_CHECKSUM_METHOD;
      csr_wdata <= {4'($urandom), meth};
      @(posedge clock);
      csr_we <= 1'b0;
      board.escape_code = esc;
      board.method_code = meth;
   endtask

   // start plus payload; the last byte sometimes steers a sum onto the delimiter
   task automatic run_frame(input int length);
      logic [7:0] b;
      logic [3:0] fc;
      logic [7:0] ctl;
      int         steer;
      ctl   = pick_byte();
      fc    = ($urandom_range(0, 3) == 0) ? 4'hE : 4'($urandom);
      steer = $urandom_range(0, 3);
      send_item(make_start(ctl[7:4], ctl[3:0], fc, pick_byte(), pick_byte()));
      payload_items++;
      for (int k = 0; k < length; k++) begin
         b = pick_byte();
         if (k == FRAME_LEN - 1 && steer == 1) b = DELIM_BYTE - board.sum_a;
         if (k == FRAME_LEN - 1 && steer == 2) b = DELIM_BYTE - board.sum_b - board.sum_a;
         send_item(make_data(b));
         payload_items++;
      end
   endtask

   // result side: random stalls, plus a long hold-off on request
   initial begin : result_sink
      int             stall;
      frame_byte_type got;
      @(negedge reset);
      forever begin
         if (rsp_hold > 0) begin
            stall    = rsp_hold;
            rsp_hold = 0;
         end else begin
            stall = rsp_idle ? $urandom_range(0, 13) : 0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         got.out_byte  = rsp_bus.out_byte;
         got.run_last  = rsp_bus.run_last;
         got.frame_end = rsp_bus.frame_end;
         board.check_result(got);
      end
   end

   // watchdog
   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

   // main sequence
   initial begin
      logic [7:0] b;
      int         target;
      int         roll;
      board = new();
      req_bus.valid       <= 1'b0;
      req_bus.cmd         <= CMD_START;
      req_bus.seq_num     <= '0;
      req_bus.ack_num     <= '0;
      req_bus.frame_count <= '0;
      req_bus.src_addr    <= '0;
      req_bus.dst_addr    <= '0;
      req_bus.data_byte   <= '0;
      rsp_bus.ready       <= 1'b0;
      csr_we              <= 1'b0;
      csr_index           <= CSR_ESCAPE_BYTE;
      csr_wdata           <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: stray payload, delimiter-valued header fields, abandoned frame
      send_item(make_data(8'h55));
      send_item(make_start(4'h7, 4'hE, 4'hE, DELIM_BYTE, DELIM_BYTE));
      send_item(make_data(DELIM_BYTE));
      send_item(make_data(8'hFF));
      send_item(make_start(4'h0, 4'h0, 4'h0, 8'hFF, 8'h00));
      for (int k = 0; k < FRAME_LEN; k++) begin
         case (k)
            0: b = DELIM_BYTE;
            1: b = board.escape_code;
            2: b = 8'h00;
            3: b = 8'hFF;
            default: b = pick_byte();
         endcase
         if (k == FRAME_LEN - 1) b = DELIM_BYTE - board.sum_a;
         send_item(make_data(b));
      end
      send_item(make_data(DELIM_BYTE));
      send_item(make_start(4'hF, 4'hF, 4'hF, 8'h7D, 8'hFF));

      // random phases, each under its own register setting
      for (int p = 0; p < 5; p++) begin
         drain_results();
         case (p)
            0: write_config(8'h00, 4'hF);
            1: write_config(8'hFF, 4'h0);
            2: write_config(DELIM_BYTE, 4'h7);
            3: write_config(8'($urandom), 4'($urandom));
            default: write_config(ESCAPE_RESET, 4'($urandom));
         endcase
         // back-pressure: receiver holds while the sender keeps offering
         if (p == 1) begin
            send_idle = 1'b0;
            rsp_hold  = LONG_HOLD;
            run_frame(FRAME_LEN);
         end
         target = payload_items + PHASE_ITEMS;
         while (payload_items < target) begin
            send_idle = ($urandom_range(0, 2) != 0);
            rsp_idle  = ($urandom_range(0, 2) != 0);
            roll      = $urandom_range(0, 9);
            if (roll == 0 && !board.open_frame) begin
               repeat ($urandom_range(1, 3)) send_item(make_data(pick_byte()));
            end else if (roll <= 2) begin
               run_frame($urandom_range(0, FRAME_LEN - 1));
            end else begin
               run_frame(FRAME_LEN);
            end
            if ($urandom_range(0, 7) == 0) drain_results();
         end
      end

      drain_results();
      if (board.fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule : tb_top
